FILE: design/triangle_raster_depth_test_core_assert.svh
// Assertion macros for the checker file.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_CORE_ASSERT_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define TRDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trdt assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define TRDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trdt assertion failed");

`endif

FILE: design/trdt_pkg.sv
package trdt_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam int COORD_W = 12;             // pixel coordinate, covers the largest screen
    localparam int VTX_W   = 16;             // 12.4 vertex coordinate
    localparam int Z_W     = 24;
    localparam logic [Z_W-1:0] FAR_DEPTH = '1;
    localparam int COLOR_W = 24;

    localparam int EDGE_W  = VTX_W + 1;      // vertex minus vertex
    localparam int OFS_W   = VTX_W + 2;      // pixel center minus vertex
    localparam int PROD_W  = EDGE_W + OFS_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;
    localparam int DEN_W   = MAG_W + 2;
    localparam int NUMP_W  = MAG_W + Z_W;
    localparam int NUM_W   = NUMP_W + 3;
    localparam int QUO_W   = Z_W;
    localparam int QCNT_W  = $clog2(QUO_W);
    localparam int BOX_W   = 14;             // floored box bound, signed

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // next vertex around the triangle
    localparam int NEXT_V [3] = '{1, 2, 0};

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        BS_INIT,
        BS_IDLE,
        BS_CLEAR,
        BS_DIFF,
        BS_MUL,
        BS_CROSS,
        BS_NUM,
        BS_SUM,
        BS_DIV,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VTX_W-1:0] vert0_x;
        logic signed [VTX_W-1:0] vert0_y;
        logic [Z_W-1:0]          vert0_z;
        logic signed [VTX_W-1:0] vert1_x;
        logic signed [VTX_W-1:0] vert1_y;
        logic [Z_W-1:0]          vert1_z;
        logic signed [VTX_W-1:0] vert2_x;
        logic signed [VTX_W-1:0] vert2_y;
        logic [Z_W-1:0]          vert2_z;
        logic [COLOR_W-1:0]      tri_color;
    } t_in_item;

    typedef struct packed {
        logic [8:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               pixel_written;
        logic               scan_last;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        t_in_item           tri_data;
    } t_cmd;

endpackage

FILE: design/triangle_raster_depth_test_core.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_in_item  (t_in_item)
// output    o_out_valid / i_out_ready  o_out_item (t_out_item)
// config    i_cfg_we                   i_cfg_index, i_cfg_data
//
// A pixel step in the back end runs from the queue pop: the pop cycle,
// five datapath stages for the edge functions and weights, a restoring
// divider for the depth, then the compare and depth store write. A triangle
// load is registered by the front end on accept. A depth clear walks the
// store one entry a cycle over all MAX_WIDTH*MAX_HEIGHT entries; the same pass
// runs after reset, with o_in_ready low until it is done. Reset is synchronous,
// active low. A two-entry command queue lets the front keep taking
// transactions while the back works or waits on a stalled output register.
module triangle_raster_depth_test_core
    import trdt_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;

    logic  init_busy, q_ready, q_valid, push, pop;
    t_cmd  push_cmd, pop_cmd;

    // hold the screen size; the user must write only while idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(512);
            r_cfg_h <= CFG_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    // clamp the screen size to 1..MAX
    assign eff_w = (r_cfg_w == '0) ? WW'(1) :
                   ((32'(r_cfg_w) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_cfg_w));
    assign eff_h = (r_cfg_h == '0) ? HW'(1) :
                   ((32'(r_cfg_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_cfg_h));

    // front: take transactions, set up the box, walk the scan
    trdt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_eff_w     (eff_w),
        .i_eff_h     (eff_h),
        .i_init_busy (init_busy),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // queue: decouple the front from the slow back end
    trdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd),
        .i_pop   (pop)
    );

    // back: depth interpolation, depth test and store clears
    trdt_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .i_eff_w     (eff_w),
        .i_eff_h     (eff_h),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/trdt_ram.sv
module trdt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/trdt_front.sv
module trdt_front
    import trdt_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in_item,
    input  logic [WW-1:0] i_eff_w,
    input  logic [HW-1:0] i_eff_h,
    input  logic          i_init_busy,
    input  logic          i_q_ready,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic          r_active;
    logic [XW-1:0] r_col, r_x_hi;
    logic [YW-1:0] r_row, r_y_lo, r_y_hi;

    logic signed [VTX_W-1:0] min_x, max_x, min_y, max_y;
    logic signed [VTX_W:0]   hx, hy;
    logic signed [BOX_W-1:0] lo_x, hi_x, lo_y, hi_y, lim_x, lim_y;
    logic signed [BOX_W-1:0] clo_x, chi_x, clo_y, chi_y;
    logic                    box_empty, accept, last;

    // bounding box of the incoming triangle, floored to pixels and clipped
    always_comb begin
        min_x = i_in_item.vert0_x;
        max_x = i_in_item.vert0_x;
        min_y = i_in_item.vert0_y;
        max_y = i_in_item.vert0_y;
        if (i_in_item.vert1_x < min_x) min_x = i_in_item.vert1_x;
        if (i_in_item.vert1_x > max_x) max_x = i_in_item.vert1_x;
        if (i_in_item.vert1_y < min_y) min_y = i_in_item.vert1_y;
        if (i_in_item.vert1_y > max_y) max_y = i_in_item.vert1_y;
        if (i_in_item.vert2_x < min_x) min_x = i_in_item.vert2_x;
        if (i_in_item.vert2_x > max_x) max_x = i_in_item.vert2_x;
        if (i_in_item.vert2_y < min_y) min_y = i_in_item.vert2_y;
        if (i_in_item.vert2_y > max_y) max_y = i_in_item.vert2_y;
        hx    = (VTX_W+1)'(max_x) + (VTX_W+1)'(15);
        hy    = (VTX_W+1)'(max_y) + (VTX_W+1)'(15);
        lo_x  = BOX_W'(min_x >>> 4);
        lo_y  = BOX_W'(min_y >>> 4);
        hi_x  = BOX_W'(hx >>> 4);
        hi_y  = BOX_W'(hy >>> 4);
        lim_x = $signed(BOX_W'({1'b0, i_eff_w}) - BOX_W'(1));
        lim_y = $signed(BOX_W'({1'b0, i_eff_h}) - BOX_W'(1));
        clo_x = (lo_x < 0) ? '0 : lo_x;
        clo_y = (lo_y < 0) ? '0 : lo_y;
        chi_x = (hi_x > lim_x) ? lim_x : hi_x;
        chi_y = (hi_y > lim_y) ? lim_y : hi_y;
        box_empty = (clo_x > chi_x) || (clo_y > chi_y);
    end

    assign o_in_ready = !i_init_busy && i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign last       = (r_col == r_x_hi) && (r_row == r_y_hi);

    always_comb begin
        o_push       = 1'b0;
        o_cmd.op     = OP_LOAD;
        o_cmd.x      = COORD_W'(r_col);
        o_cmd.y      = COORD_W'(r_row);
        o_cmd.last   = last;
        o_cmd.tri_data = i_in_item;
        unique case (i_in_item.mode)
            MODE_LOAD: begin
                o_push   = accept;
                o_cmd.op = OP_LOAD;
            end
            MODE_STEP: begin
                o_push   = accept && r_active;
                o_cmd.op = OP_PIXEL;
            end
            MODE_CLEAR: begin
                o_push   = accept;
                o_cmd.op = OP_CLEAR;
            end
            MODE_NONE: begin
                o_push   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_x_hi   <= '0;
            r_y_lo   <= '0;
            r_y_hi   <= '0;
        end else if (accept) begin
            if (i_in_item.mode == MODE_LOAD) begin
                r_active <= !box_empty;
                if (!box_empty) begin
                    r_col  <= XW'(clo_x);
                    r_x_hi <= XW'(chi_x);
                    r_row  <= YW'(clo_y);
                    r_y_lo <= YW'(clo_y);
                    r_y_hi <= YW'(chi_y);
                end
            end else if (i_in_item.mode == MODE_STEP && r_active) begin
                // column-major walk: row first, then column
                if (last) begin
                    r_active <= 1'b0;
                end else if (r_row == r_y_hi) begin
                    r_row <= r_y_lo;
                    r_col <= r_col + XW'(1);
                end else begin
                    r_row <= r_row + YW'(1);
                end
            end
        end
    end

endmodule

FILE: design/trdt_queue.sv
module trdt_queue
    import trdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              do_pop;

    assign o_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) r_wp <= r_wp + Q_AW'(1);
            if (do_pop)            r_rp <= r_rp + Q_AW'(1);
            if ((i_push && o_ready) && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!(i_push && o_ready) && do_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule

FILE: design/trdt_back.sv
module trdt_back
    import trdt_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int YW    = $clog2(MAX_HEIGHT),
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    input  logic [WW-1:0] i_eff_w,
    input  logic [HW-1:0] i_eff_h,
    output logic          o_init_busy,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_item     o_out_item
);

    t_bstate r_state, n_state;

    logic [AW-1:0]           r_clr_addr;
    t_in_item                r_tri;
    logic [COORD_W-1:0]      r_px, r_py;
    logic                    r_last;
    logic signed [EDGE_W-1:0]  r_ex [3];
    logic signed [EDGE_W-1:0]  r_ey [3];
    logic signed [OFS_W-1:0]   r_qx [3];
    logic signed [OFS_W-1:0]   r_qy [3];
    logic signed [PROD_W-1:0]  r_m1 [3];
    logic signed [PROD_W-1:0]  r_m2 [3];
    logic signed [CROSS_W-1:0] r_c  [3];
    logic [NUMP_W-1:0]       r_p [3];
    logic [DEN_W-1:0]        r_den;
    logic                    r_inside, r_inb;
    logic [NUM_W-1:0]        r_rem, r_dsh;
    logic [QUO_W-1:0]        r_quo;
    logic [QCNT_W-1:0]       r_cnt;
    logic [AW-1:0]           r_addr;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic signed [VTX_W-1:0] vx [3];
    logic signed [VTX_W-1:0] vy [3];
    logic [Z_W-1:0]          vz [3];
    logic signed [OFS_W-1:0] pcx, pcy;
    logic [YW-1:0]           flip_y;
    logic [YW+WW-1:0]        row_base;
    logic [MAG_W-1:0]        mag [3];
    logic                    all_neg, all_pos, div_ge, wr, emit;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [Z_W-1:0]          ram_wdata, ram_rdata;

    assign vx[0] = r_tri.vert0_x;
    assign vx[1] = r_tri.vert1_x;
    assign vx[2] = r_tri.vert2_x;
    assign vy[0] = r_tri.vert0_y;
    assign vy[1] = r_tri.vert1_y;
    assign vy[2] = r_tri.vert2_y;
    assign vz[0] = r_tri.vert0_z;
    assign vz[1] = r_tri.vert1_z;
    assign vz[2] = r_tri.vert2_z;

    // pixel center in 1/16 units
    assign pcx = $signed({2'b00, r_px, 4'b1000});
    assign pcy = $signed({2'b00, r_py, 4'b1000});

    // store row zero is the top row of the screen
    assign flip_y   = YW'(i_eff_h - HW'(1)) - YW'(r_py);
    assign row_base = (YW+WW)'(flip_y) * (YW+WW)'(i_eff_w);

    assign all_neg = (r_c[0] < 0) && (r_c[1] < 0) && (r_c[2] < 0);
    assign all_pos = (r_c[0] >= 0) && (r_c[1] >= 0) && (r_c[2] >= 0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = all_neg ? MAG_W'(-r_c[k]) : MAG_W'(r_c[k]);
        end
    end

    assign div_ge = (r_rem >= r_dsh);
    assign wr     = r_inside && (r_den != '0) && r_inb && (r_quo < ram_rdata);

    trdt_ram #(
        .WIDTH (Z_W),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_quo;
        emit      = 1'b0;
        unique case (r_state)
            BS_INIT, BS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = FAR_DEPTH;
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = BS_IDLE;
            end
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CLEAR: n_state = BS_CLEAR;
                        OP_PIXEL: n_state = BS_DIFF;
                        default:  n_state = BS_IDLE;
                    endcase
                end
            end
            BS_DIFF:  n_state = BS_MUL;
            BS_MUL:   n_state = BS_CROSS;
            BS_CROSS: n_state = BS_NUM;
            BS_NUM:   n_state = BS_SUM;
            BS_SUM:   n_state = BS_DIV;
            BS_DIV: begin
                if (r_cnt == '0) n_state = BS_DONE;
            end
            BS_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    emit    = 1'b1;
                    ram_we  = wr;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == BS_INIT || r_state == BS_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end else begin
            r_clr_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid && i_cmd.op == OP_LOAD) begin
                    r_tri <= i_cmd.tri_data;
                end
                r_px   <= i_cmd.x;
                r_py   <= i_cmd.y;
                r_last <= i_cmd.last;
            end
            BS_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_ex[k] <= EDGE_W'(vx[k]) - EDGE_W'(vx[NEXT_V[k]]);
                    r_ey[k] <= EDGE_W'(vy[k]) - EDGE_W'(vy[NEXT_V[k]]);
                    r_qx[k] <= pcx - OFS_W'(vx[NEXT_V[k]]);
                    r_qy[k] <= pcy - OFS_W'(vy[NEXT_V[k]]);
                end
                r_inb  <= (32'(r_px) < 32'(i_eff_w)) && (32'(r_py) < 32'(i_eff_h));
                r_addr <= AW'(row_base) + AW'(r_px);
            end
            BS_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_m1[k] <= PROD_W'(r_ex[k]) * PROD_W'(r_qy[k]);
                    r_m2[k] <= PROD_W'(r_ey[k]) * PROD_W'(r_qx[k]);
                end
            end
            BS_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    r_c[k] <= CROSS_W'(r_m1[k]) - CROSS_W'(r_m2[k]);
                end
            end
            BS_NUM: begin
                // weight of vertex k is the edge opposite to it
                for (int k = 0; k < 3; k++) begin
                    r_p[k] <= NUMP_W'(mag[NEXT_V[k]]) * NUMP_W'(vz[k]);
                end
                r_den    <= DEN_W'(mag[0]) + DEN_W'(mag[1]) + DEN_W'(mag[2]);
                r_inside <= all_neg || all_pos;
            end
            BS_SUM: begin
                // round to nearest: add half the divisor before dividing
                r_rem <= NUM_W'(r_p[0]) + NUM_W'(r_p[1]) + NUM_W'(r_p[2])
                         + NUM_W'(r_den >> 1);
                r_dsh <= NUM_W'(r_den) << (QUO_W - 1);
                r_quo <= '0;
                r_cnt <= QCNT_W'(QUO_W - 1);
            end
            BS_DIV: begin
                if (div_ge) r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - QCNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.pixel_x       <= 9'(r_px);
            r_out.pixel_y       <= 9'(r_py);
            r_out.pixel_color   <= wr ? r_tri.tri_color : '0;
            r_out.pixel_written <= wr;
            r_out.scan_last     <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_init_busy = (r_state == BS_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: design/trdt_checker.sv
module trdt_checker
    import trdt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item
);

`include "triangle_raster_depth_test_core_assert.svh"

    // a stalled result stays offered
    `TRDT_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // a pixel that is not written carries no color
    `TRDT_ASSERT_IMP(a_no_color, o_out_valid && !o_out_item.pixel_written, o_out_item.pixel_color == '0)

    // right after reset nothing is offered and the store clear blocks input
    `TRDT_ASSERT_IMP(a_reset_quiet, !$past(i_rst_n), !o_out_valid && !o_in_ready)

endmodule

bind triangle_raster_depth_test_core trdt_checker u_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

import trdt_pkg::*;

// Tracks the rasterizer state from accepted transactions and holds the
// pixel results it expects, oldest first.
class raster_scoreboard;
    localparam int MAX_PIXELS = 512 * 512;

    logic [Z_W-1:0]     depth_mem [MAX_PIXELS];
    longint             vx [3];
    longint             vy [3];
    longint unsigned    vz [3];
    logic [COLOR_W-1:0] color;
    longint             x_lo, x_hi, y_lo, y_hi;
    longint             col, row;
    bit                 active;
    logic [CFG_W-1:0]   width_reg, height_reg;
    t_out_item          pixel_q [$];
    int                 errors;

    function new();
        foreach (depth_mem[i]) depth_mem[i] = FAR_DEPTH;
        foreach (vx[k]) begin
            vx[k] = 0;
            vy[k] = 0;
            vz[k] = 0;
        end
        color = '0;
        x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0;
        col = 0; row = 0;
        active = 0;
        width_reg = 512;
        height_reg = 512;
        errors = 0;
    endfunction

    function longint clamp_dim(logic [CFG_W-1:0] r);
        if (r < 1) return 1;
        if (r > 512) return 512;
        return r;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == CFG_SCREEN_WIDTH) width_reg = val;
        else height_reg = val;
    endfunction

    function int pending();
        return pixel_q.size();
    endfunction

    function longint box_pixels();
        if (!active) return 0;
        return (x_hi - x_lo + 1) * (y_hi - y_lo + 1);
    endfunction

    function void load_triangle(t_in_item it);
        longint lx, hx, ly, hy, w, h;
        vx[0] = longint'(it.vert0_x); vy[0] = longint'(it.vert0_y); vz[0] = it.vert0_z;
        vx[1] = longint'(it.vert1_x); vy[1] = longint'(it.vert1_y); vz[1] = it.vert1_z;
        vx[2] = longint'(it.vert2_x); vy[2] = longint'(it.vert2_y); vz[2] = it.vert2_z;
        color = it.tri_color;
        lx = vx[0]; hx = vx[0]; ly = vy[0]; hy = vy[0];
        for (int k = 1; k < 3; k++) begin
            if (vx[k] < lx) lx = vx[k];
            if (vx[k] > hx) hx = vx[k];
            if (vy[k] < ly) ly = vy[k];
            if (vy[k] > hy) hy = vy[k];
        end
        // floor to whole pixels, rounding the upper bound up
        lx = lx >>> 4; hx = (hx + 15) >>> 4;
        ly = ly >>> 4; hy = (hy + 15) >>> 4;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > w - 1) hx = w - 1;
        if (hy > h - 1) hy = h - 1;
        if (lx > hx || ly > hy) begin
            active = 0;
            return;
        end
        x_lo = lx; x_hi = hx; y_lo = ly; y_hi = hy;
        col = lx;
        row = ly;
        active = 1;
    endfunction

    // Edge test at the pixel center, then interpolated depth against the store.
    function bit shade_pixel(longint x, longint y);
        longint w, h, px, py, c1, c2, c3, idx;
        longint unsigned num, den, depth;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (x >= w || y >= h) return 0;
        px = 16 * x + 8;
        py = 16 * y + 8;
        c1 = (vx[0] - vx[1]) * (py - vy[1]) - (vy[0] - vy[1]) * (px - vx[1]);
        c2 = (vx[1] - vx[2]) * (py - vy[2]) - (vy[1] - vy[2]) * (px - vx[2]);
        c3 = (vx[2] - vx[0]) * (py - vy[0]) - (vy[2] - vy[0]) * (px - vx[0]);
        if (c1 < 0 && c2 < 0 && c3 < 0) begin
            c1 = -c1; c2 = -c2; c3 = -c3;
        end else if (!(c1 >= 0 && c2 >= 0 && c3 >= 0)) begin
            return 0;
        end
        den = c1 + c2 + c3;
        if (den == 0) return 0;
        num = longint'(c2) * vz[0] + longint'(c3) * vz[1] + longint'(c1) * vz[2];
        depth = (num + den / 2) / den;
        if (depth > FAR_DEPTH) depth = FAR_DEPTH;
        idx = (h - 1 - y) * w + x;
        if (depth < depth_mem[idx]) begin
            depth_mem[idx] = Z_W'(depth);
            return 1;
        end
        return 0;
    endfunction

    function void note_input(t_in_item it);
        t_out_item res;
        bit wr, last;
        case (it.mode)
            MODE_LOAD:  load_triangle(it);
            MODE_CLEAR: foreach (depth_mem[i]) depth_mem[i] = FAR_DEPTH;
            MODE_STEP: begin
                if (active) begin
                    last = (col == x_hi && row == y_hi);
                    wr = shade_pixel(col, row);
                    res.pixel_x = 9'(col);
                    res.pixel_y = 9'(row);
                    res.pixel_color = wr ? color : '0;
                    res.pixel_written = wr;
                    res.scan_last = last;
                    pixel_q.push_back(res);
                    // column-major: advance the row first, then wrap to the next column
                    if (last) begin
                        active = 0;
                    end else if (row == y_hi) begin
                        row = y_lo;
                        col = col + 1;
                    end else begin
                        row = row + 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(t_out_item got);
        t_out_item exp;
        if (pixel_q.size() == 0) begin
            errors++;
            $error("unexpected pixel result x=%0d y=%0d", got.pixel_x, got.pixel_y);
            return;
        end
        exp = pixel_q.pop_front();
        if (got.pixel_x != exp.pixel_x) begin
            errors++;
            $error("pixel_x exp %0d got %0d", exp.pixel_x, got.pixel_x);
        end
        if (got.pixel_y != exp.pixel_y) begin
            errors++;
            $error("pixel_y exp %0d got %0d", exp.pixel_y, got.pixel_y);
        end
        if (got.pixel_color != exp.pixel_color) begin
            errors++;
            $error("pixel_color exp %06h got %06h", exp.pixel_color, got.pixel_color);
        end
        if (got.pixel_written != exp.pixel_written) begin
            errors++;
            $error("pixel_written exp %0d got %0d", exp.pixel_written, got.pixel_written);
        end
        if (got.scan_last != exp.scan_last) begin
            errors++;
            $error("scan_last exp %0d got %0d", exp.scan_last, got.scan_last);
        end
    endfunction
endclass

module tb_top;
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    raster_scoreboard pixel_sb = new();

    int send_idle_pct = 0;   // chance of a gap before each input transaction
    int recv_idle_pct = 0;   // chance of dropping ready on each cycle
    int hold_left = 0;       // long receiver stall, counted down by the receiver
    int item_count = 0;

    triangle_raster_depth_test_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Ends a hung run; the bound is far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

    // Receiver: check each output transaction, then pick next cycle's ready.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) pixel_sb.check_result(o_out_item);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom % 100) >= recv_idle_pct;
            end
        end
    end

    // Offer one transaction and hold it until accepted; valid stays high on return.
    task automatic send_item(t_in_item it);
        if (send_idle_pct > 0 && ($urandom % 100) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pixel_sb.note_input(it);
        item_count++;
    endtask

    // Mode-only item with random filler in the unused fields.
    task automatic send_mode(t_mode m);
        t_in_item it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.mode = m;
        send_item(it);
    endtask

    task automatic send_steps(int n);
        for (int i = 0; i < n; i++) send_mode(MODE_STEP);
    endtask

    task automatic send_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                                 int z0, int z1, int z2, int c);
        t_in_item it;
        it.mode = MODE_LOAD;
        it.vert0_x = VTX_W'(x0); it.vert0_y = VTX_W'(y0); it.vert0_z = Z_W'(z0);
        it.vert1_x = VTX_W'(x1); it.vert1_y = VTX_W'(y1); it.vert1_z = Z_W'(z1);
        it.vert2_x = VTX_W'(x2); it.vert2_y = VTX_W'(y2); it.vert2_z = Z_W'(z2);
        it.tri_color = COLOR_W'(c);
        send_item(it);
    endtask

    // Drop valid, drain every expected pixel, then let trailing loads settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixel_sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pixel_sb.set_cfg(idx, CFG_W'(val));
    endtask

    function automatic int rand_depth();
        case ($urandom % 6)
            0:       return 0;
            1:       return int'(FAR_DEPTH);
            default: return int'($urandom & 24'hFFFFFF);
        endcase
    endfunction

    // One random triangle and the steps over (most of) its box.
    task automatic random_group(int scr_w, int scr_h);
        t_in_item it;
        logic [223:0] raw;
        int bx, by, vxs [3], vys [3], r;
        longint npix;
        r = $urandom % 100;
        if (r < 8) begin
            // noise: arbitrary vertices, mostly off screen or huge boxes
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(t_in_item)-1:0];
            it.mode = MODE_LOAD;
            send_item(it);
            send_steps($urandom_range(0, 6));
        end else if (r < 12) begin
            send_mode(($urandom % 2) ? MODE_NONE : MODE_STEP);
        end else begin
            // keep most triangles near the origin so they overlap in depth
            if ($urandom % 10 < 6) begin
                bx = $urandom_range(0, 12);
                by = $urandom_range(0, 12);
            end else begin
                bx = $urandom_range(0, scr_w + 1);
                by = $urandom_range(0, scr_h + 1);
            end
            for (int k = 0; k < 3; k++) begin
                vxs[k] = bx * 16 + $urandom_range(0, 96) - 16;
                vys[k] = by * 16 + $urandom_range(0, 96) - 16;
            end
            send_triangle(vxs[0], vys[0], vxs[1], vys[1], vxs[2], vys[2],
                          rand_depth(), rand_depth(), rand_depth(), $urandom);
            npix = pixel_sb.box_pixels();
            r = $urandom % 10;
            if (npix > 64) send_steps($urandom_range(0, 40));
            else if (r == 0) send_steps($urandom_range(0, int'(npix)));
            else if (r == 1) send_steps(int'(npix) + int'($urandom_range(1, 2)));
            else send_steps(int'(npix));
        end
    endtask

    initial begin
        int widths [6];
        int heights [6];
        int target;
        int cw, ch;

        widths  = '{512, 1023, 1, 40, 512, 9};
        heights = '{512, 0, 512, 23, 1, 300};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle scan, ignored mode, degenerate, both windings, clear.
        send_mode(MODE_STEP);
        send_mode(MODE_NONE);
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
        send_steps(1);
        send_triangle(8, 8, 40, 8, 8, 40, 0, FAR_DEPTH, 24'h800000, 24'hFFFFFF);
        send_steps(4);
        // reload mid-scan with the opposite winding and nearer depth
        send_triangle(8, 8, 8, 40, 40, 8, 5, 5, 5, 24'h00FF00);
        send_steps(9);
        send_mode(MODE_CLEAR);
        send_triangle(-32768, -32768, -32768, 32767, -32768, 0, 1, 2, 3, 24'h123456);
        send_mode(MODE_STEP);
        send_triangle(32767, 32767, 32767, -32768, 32767, 0, 1, 2, 3, 24'h654321);
        send_triangle(8, 8, 40, 8, 8, 40, FAR_DEPTH, FAR_DEPTH, FAR_DEPTH, 24'hABCDEF);
        send_steps(9);
        // leave a scan open across the first register change
        send_triangle(0, 0, 160, 0, 0, 160, 100, 200, 300, 24'h0F0F0F);
        send_steps(3);
        drain();

        // Random part: six register settings, idling pattern changes every two.
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_SCREEN_WIDTH, widths[ph]);
            write_cfg(CFG_SCREEN_HEIGHT, heights[ph]);
            cw = int'(pixel_sb.clamp_dim(CFG_W'(widths[ph])));
            ch = int'(pixel_sb.clamp_dim(CFG_W'(heights[ph])));
            send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 82 : 0;
            recv_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 26 : 0;
            if (ph == 1 || ph == 4) hold_left = 400;
            target = item_count + 175;
            while (item_count < target) begin
                random_group(cw, ch);
                // one more full clear, mid-phase so a scan follows it
                if (ph == 3 && item_count > target - 100 && item_count < target - 90)
                    send_mode(MODE_CLEAR);
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
